### sv/command_frame_deframer_defines.svh
// Assertion macros used by the command frame deframer datapath.
`ifndef COMMAND_FRAME_DEFRAMER_DEFINES_SVH
`define COMMAND_FRAME_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cfd_pkg.sv
// Types, constants and control structs shared by the command frame deframer.
`default_nettype none

package cfd_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
    localparam int WIN_IDX_W   = $clog2(FRAME_BYTES);
    localparam int CFG_ADDR_W  = 2;

    typedef logic [7:0]            byte_t;
    typedef logic [FILL_W-1:0]     fill_t;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam fill_t FILL_FULL = fill_t'(FRAME_BYTES);

    // Configuration register indexes.
    localparam cfg_addr_t REG_START_MARKER     = 2'd0;
    localparam cfg_addr_t REG_END_MARKER       = 2'd1;
    localparam cfg_addr_t REG_EXPECTED_VERSION = 2'd2;

    // Reset values of the configuration registers.
    localparam byte_t START_MARKER_RST     = 8'hAA;
    localparam byte_t END_MARKER_RST       = 8'h55;
    localparam byte_t EXPECTED_VERSION_RST = 8'h01;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_byte;
        logic shift;
        logic clear;
        logic emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_zero;
        logic fill_full;
        logic head_is_start;
        logic frame_ok;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### sv/cfd_ctrl.sv
// Controller state machine that sequences byte intake and window rescans.
`default_nettype none

module cfd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire cfd_pkg::dp_status_t stat,
    output cfd_pkg::dp_cmd_t        cmd
);
    import cfd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_byte = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.fill_zero) begin
                    state_next = ST_IDLE;
                end else if (!stat.head_is_start) begin
                    cmd.shift = 1'b1;
                end else if (!stat.fill_full) begin
                    state_next = ST_IDLE;
                end else if (stat.frame_ok) begin
                    // A good frame waits here until the output register can take it.
                    if (stat.out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.shift = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/cfd_datapath.sv
// Datapath: configuration registers, byte window, frame check and output register.
`default_nettype none
`include "command_frame_deframer_defines.svh"

module cfd_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire cfd_pkg::cfg_addr_t  cfg_addr,
    input  wire cfd_pkg::byte_t      cfg_wdata,
    input  wire cfd_pkg::byte_t      rx_byte,
    input  wire cfd_pkg::dp_cmd_t    cmd,
    output cfd_pkg::dp_status_t      stat,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output cfd_pkg::byte_t           m_channel_count_a,
    output cfd_pkg::byte_t           m_channel_count_b,
    output cfd_pkg::byte_t           m_channel_count_c,
    output cfd_pkg::byte_t           m_channel_count_d
);
    import cfd_pkg::*;

    byte_t start_marker_reg;
    byte_t end_marker_reg;
    byte_t expected_version_reg;

    byte_t window_reg [FRAME_BYTES];
    fill_t fill_reg;
    fill_t fill_next;

    logic  m_valid_reg;
    byte_t count_a_reg;
    byte_t count_b_reg;
    byte_t count_c_reg;
    byte_t count_d_reg;

    byte_t checksum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg     <= START_MARKER_RST;
            end_marker_reg       <= END_MARKER_RST;
            expected_version_reg <= EXPECTED_VERSION_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_START_MARKER:     start_marker_reg     <= cfg_wdata;
                REG_END_MARKER:       end_marker_reg       <= cfg_wdata;
                REG_EXPECTED_VERSION: expected_version_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The window is a shift line; new bytes land just past the last valid one.
    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            window_reg[fill_reg[WIN_IDX_W-1:0]] <= rx_byte;
        end else if (cmd.shift) begin
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                window_reg[i] <= window_reg[i+1];
            end
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (cmd.clear) begin
            fill_next = '0;
        end else if (cmd.load_byte) begin
            fill_next = fill_reg + fill_t'(1);
        end else if (cmd.shift) begin
            fill_next = fill_reg - fill_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // Additive checksum over version and the four counts, modulo 256.
    assign checksum = window_reg[1] + window_reg[2] + window_reg[3]
                    + window_reg[4] + window_reg[5];

    assign stat.fill_zero     = (fill_reg == '0);
    assign stat.fill_full     = (fill_reg == FILL_FULL);
    assign stat.head_is_start = (window_reg[0] == start_marker_reg);
    assign stat.frame_ok      = (window_reg[FRAME_BYTES-1] == end_marker_reg)
                             && (window_reg[1] == expected_version_reg)
                             && (checksum == window_reg[6]);
    assign stat.out_free      = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            count_a_reg <= window_reg[2];
            count_b_reg <= window_reg[3];
            count_c_reg <= window_reg[4];
            count_d_reg <= window_reg[5];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_channel_count_a = count_a_reg;
    assign m_channel_count_b = count_b_reg;
    assign m_channel_count_c = count_c_reg;
    assign m_channel_count_d = count_d_reg;

    `CFD_ASSERT_SAME(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= FILL_FULL, "fill level above frame size")
    `CFD_ASSERT_SAME(a_load_not_full, aclk, aresetn, cmd.load_byte, !stat.fill_full, "byte loaded into a full window")
    `CFD_ASSERT_SAME(a_emit_checked, aclk, aresetn, cmd.emit, stat.fill_full && stat.frame_ok && stat.out_free, "frame emitted without a passing check")
    `CFD_ASSERT_NEXT(a_emit_shows, aclk, aresetn, cmd.emit, m_valid_reg && fill_reg == '0, "emitted frame not presented or window not emptied")
    `CFD_ASSERT_SAME(a_shift_nonempty, aclk, aresetn, cmd.shift, !stat.fill_zero, "shift of an empty window")

endmodule

`default_nettype wire

### sv/command_frame_deframer.sv
// Top level of the command frame deframer: controller plus datapath.
`default_nettype none

// Receives one byte per request and hunts for frames of eight bytes: start marker,
// version, four channel counts, checksum (low eight bits of the sum of version and
// counts) and end marker. Each good frame yields one result with the four counts;
// a bad frame loses its first byte and the rest is rescanned for a start marker.
// A byte enters the window and the window is then rescanned; no new byte is taken
// until the rescan ends, and a rejected frame is shifted out byte by byte, since
// the window moves one position per cycle. A good frame also
// waits while the previous result is still held in the output register.
// The marker and version registers may be written only while no byte is in flight.
module command_frame_deframer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire cfd_pkg::cfg_addr_t cfg_addr,
    input  wire cfd_pkg::byte_t     cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire cfd_pkg::byte_t     s_rx_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output cfd_pkg::byte_t          m_channel_count_a,
    output cfd_pkg::byte_t          m_channel_count_b,
    output cfd_pkg::byte_t          m_channel_count_c,
    output cfd_pkg::byte_t          m_channel_count_d
);
    import cfd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    cfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cfd_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .rx_byte           (s_rx_byte),
        .cmd               (cmd),
        .stat              (stat),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_channel_count_a (m_channel_count_a),
        .m_channel_count_b (m_channel_count_b),
        .m_channel_count_c (m_channel_count_c),
        .m_channel_count_d (m_channel_count_d)
    );

endmodule

`default_nettype wire
